[design/kmeans_clustering_engine_assert.svh]
// Assertion macros for the k-means engine.
// Used by the top level; expects clk and rst in scope.
`ifndef KMEANS_CLUSTERING_ENGINE_ASSERT_SVH
`define KMEANS_CLUSTERING_ENGINE_ASSERT_SVH

// same-cycle implication
`define KCE_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KCE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/kce_pkg.sv]
// Shared types, constants and helpers for the k-means engine.
// No dependencies.
package kce_pkg;

  localparam int MAX_POINT_COUNT = 1024;
  localparam int MAX_CLUSTERS    = 8;
  localparam int MAX_DIMENSION   = 8;
  localparam int COORD_WIDTH     = 24;

  localparam int PT_AW  = $clog2(MAX_POINT_COUNT);
  localparam int DIM_W  = $clog2(MAX_DIMENSION);
  localparam int CL_W   = $clog2(MAX_CLUSTERS);
  localparam int CNT_W  = PT_AW + 1;
  localparam int SUM_W  = COORD_WIDTH + PT_AW;
  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int SQ_W   = 2 * DIFF_W;
  localparam int DIST_W = SQ_W + DIM_W;
  localparam int RAM_AW = PT_AW + DIM_W;
  localparam int RAM_DEPTH = 1 << RAM_AW;
  localparam int INIT_W = CL_W + DIM_W;

  localparam int K_W   = 4;
  localparam int DR_W  = 4;
  localparam int LIM_W = 10;
  localparam int THR_W = 40;
  localparam int CFG_W = 40;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t REG_CLUSTER_COUNT   = 2'd0;
  localparam cfg_idx_t REG_ITERATION_LIMIT = 2'd1;
  localparam cfg_idx_t REG_DIMENSION       = 2'd2;
  localparam cfg_idx_t REG_THRESHOLD       = 2'd3;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_FEW = 1'b1;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [SUM_W-1:0]       sum_t;
  typedef logic [CNT_W-1:0]              cnt_t;
  typedef logic [DIST_W-1:0]             dist_t;

  typedef struct packed {
    logic signed [23:0] coord_value;
    logic               end_of_point;
    logic               end_of_set;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] centroid_coord;
    logic [2:0]         centroid_index;
    logic [2:0]         coord_index;
    logic               status;
    logic [9:0]         passes_run;
    logic               last_result;
  } out_item_t;

  // running minimum handed from cell to cell
  typedef struct packed {
    logic            valid;
    dist_t           best;
    logic [CL_W-1:0] idx;
  } tok_t;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic             feed_valid;
    logic [DIM_W-1:0] feed_d;
    logic             clear_pass;
    logic             clear_dist;
    logic             acc_en;
    logic [CL_W-1:0]  acc_idx;
    logic             cent_we;
    logic [CL_W-1:0]  cent_idx;
    logic [DIM_W-1:0] cent_d;
    coord_t           cent_val;
    logic [K_W-1:0]   k;
  } ctl_t;

  function automatic logic [K_W-1:0] eff_k(input logic [K_W-1:0] v);
    logic [K_W-1:0] r;
    r = v;
    if (v < K_W'(2)) r = K_W'(2);
    else if (v > K_W'(MAX_CLUSTERS)) r = K_W'(MAX_CLUSTERS);
    return r;
  endfunction

  function automatic logic [DR_W-1:0] eff_dim(input logic [DR_W-1:0] v);
    logic [DR_W-1:0] r;
    r = v;
    if (v < DR_W'(1)) r = DR_W'(1);
    else if (v > DR_W'(MAX_DIMENSION)) r = DR_W'(MAX_DIMENSION);
    return r;
  endfunction

endpackage

[design/kce_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

[design/kce_div.sv]
// Iterative signed-by-unsigned divider, one quotient bit per cycle,
// truncating toward zero. Depends on kce_pkg.
module kce_div (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  kce_pkg::sum_t   dividend,
  input  kce_pkg::cnt_t   divisor,
  output logic            done,
  output kce_pkg::coord_t quotient
);

  localparam int SW = kce_pkg::SUM_W;
  localparam int CW = kce_pkg::CNT_W;

  logic          running;
  logic [5:0]    steps;
  logic          neg;
  logic [SW-1:0] q;
  logic [CW-1:0] rem;
  kce_pkg::cnt_t dv;
  logic [CW:0]   rem_sh;
  logic          ge;
  logic [SW-1:0] q_signed;

  assign rem_sh   = {rem, q[SW-1]};
  assign ge       = rem_sh >= {1'b0, dv};
  assign q_signed = neg ? (~q + 1'b1) : q;
  assign quotient = q_signed[kce_pkg::COORD_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        steps   <= 6'(SW);
        neg     <= dividend[SW-1];
        q       <= dividend[SW-1] ? (~dividend + 1'b1) : dividend;
        rem     <= '0;
        dv      <= divisor;
      end else if (running) begin
        rem   <= ge ? CW'(rem_sh - {1'b0, dv}) : rem_sh[CW-1:0];
        q     <= {q[SW-2:0], ge};
        steps <= steps - 1'b1;
        if (steps == 6'd1) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

[design/kce_cell.sv]
// One cluster cell: centroid, coordinate sums, member count, distance
// accumulator and one link of the argmin chain. Depends on kce_pkg.
module kce_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [kce_pkg::CL_W-1:0]      cell_id,
  input  kce_pkg::ctl_t                 ctl,
  input  kce_pkg::coord_t               feed_coord,
  input  kce_pkg::coord_t               pbuf [kce_pkg::MAX_DIMENSION],
  input  kce_pkg::tok_t                 tok_in,
  output kce_pkg::tok_t                 tok_out,
  output kce_pkg::coord_t               cent [kce_pkg::MAX_DIMENSION],
  output kce_pkg::sum_t                 sums [kce_pkg::MAX_DIMENSION],
  output kce_pkg::cnt_t                 count
);

  localparam int DW = kce_pkg::DIFF_W;

  logic signed [DW-1:0]            diff_q;
  logic                            diff_v;
  logic signed [kce_pkg::SQ_W-1:0] prod;
  logic [kce_pkg::SQ_W-1:0]        sq_q;
  logic                            sq_v;
  kce_pkg::dist_t                  acc;
  logic                            active;
  logic                            take;
  logic                            mine;
  kce_pkg::coord_t                 cur;

  assign cur    = cent[ctl.feed_d];
  assign prod   = diff_q * diff_q;
  assign active = {1'b0, cell_id} < ctl.k;
  assign take   = active && (cell_id == '0 || acc < tok_in.best);
  assign mine   = ctl.acc_en && ctl.acc_idx == cell_id;

  always_ff @(posedge clk) begin
    if (rst) begin
      diff_v  <= 1'b0;
      sq_v    <= 1'b0;
      tok_out <= '0;
      count   <= '0;
    end else begin
      diff_v        <= ctl.feed_valid;
      sq_v          <= diff_v;
      tok_out.valid <= tok_in.valid;
      tok_out.best  <= take ? acc : tok_in.best;
      tok_out.idx   <= take ? cell_id : tok_in.idx;
      if (ctl.clear_pass) count <= '0;
      else if (mine) count <= count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    diff_q <= {feed_coord[kce_pkg::COORD_WIDTH-1], feed_coord}
            - {cur[kce_pkg::COORD_WIDTH-1], cur};
    sq_q   <= prod;
    if (ctl.clear_dist) acc <= '0;
    else if (sq_v) acc <= acc + kce_pkg::dist_t'(sq_q);
    for (int d = 0; d < kce_pkg::MAX_DIMENSION; d++) begin
      if (ctl.clear_pass) sums[d] <= '0;
      else if (mine) sums[d] <= sums[d] + kce_pkg::sum_t'(pbuf[d]);
    end
    if (ctl.cent_we && ctl.cent_idx == cell_id) cent[ctl.cent_d] <= ctl.cent_val;
  end

endmodule

[design/kmeans_clustering_engine.sv]
// Top level of the k-means engine: load sequencer, point memory, cell row,
// divider and result register. Depends on kce_pkg, kce_ram, kce_div,
// kce_cell and kmeans_clustering_engine_assert.svh.
//
// Usage: coordinates come in on in_data, one per transfer, one per cycle
// while loading; end_of_point closes a point, end_of_set closes the set and
// starts clustering. in_ready drops until every centroid coordinate of the
// run has been handed to the output register. Results leave on out_data,
// centroid by centroid, coordinate by coordinate, the last one flagged.
// After end_of_set the engine seeds the centroids, then on each pass handles
// every point (memory read, distance pipeline, the 8-cell argmin chain) and
// then every centroid coordinate (divider and the movement square). Output
// then runs one result per cycle while the receiver is ready. Too few points
// give one error result.
// Reset clears the state and valid flags and loads the default registers; the
// point memory is not cleared. A stalled receiver holds the result
// register; the sequencer waits for it, no result is lost.
module kmeans_clustering_engine (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  kce_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output kce_pkg::out_item_t         out_data,
  input  logic                       cfg_we,
  input  kce_pkg::cfg_idx_t          cfg_index,
  input  logic [kce_pkg::CFG_W-1:0]  cfg_data
);

  localparam int NC = kce_pkg::MAX_CLUSTERS;
  localparam int ND = kce_pkg::MAX_DIMENSION;
  localparam int CL = kce_pkg::CL_W;
  localparam int DD = kce_pkg::DIM_W;
  localparam int IW = kce_pkg::INIT_W;

  typedef enum logic [11:0] {
    ST_LOAD   = 12'b000000000001,
    ST_ERR    = 12'b000000000010,
    ST_INIT   = 12'b000000000100,
    ST_PSTART = 12'b000000001000,
    ST_DIST   = 12'b000000010000,
    ST_ARGMIN = 12'b000000100000,
    ST_DSTART = 12'b000001000000,
    ST_DWAIT  = 12'b000010000000,
    ST_MDIFF  = 12'b000100000000,
    ST_MSQ    = 12'b001000000000,
    ST_MACC   = 12'b010000000000,
    ST_OUT    = 12'b100000000000
  } state_t;

  state_t state;

  logic [kce_pkg::K_W-1:0]   cluster_count;
  logic [kce_pkg::LIM_W-1:0] iteration_limit;
  logic [kce_pkg::DR_W-1:0]  dimension;
  logic [kce_pkg::THR_W-1:0] converge_threshold_sq;

  kce_pkg::cnt_t            pl;
  logic [3:0]               cip;
  logic [kce_pkg::K_W-1:0]  run_k;
  logic [kce_pkg::DR_W-1:0] run_dim;
  logic [IW:0]              ini_cnt;
  logic                     ini_v;
  logic [IW-1:0]            ini_a;
  logic                     rd_v;
  logic [DD-1:0]            rd_d;
  kce_pkg::cnt_t            pt;
  logic [3:0]               step;
  logic                     tok_start;
  logic [CL-1:0]            j;
  logic [DD-1:0]            d;
  kce_pkg::coord_t          nv_q;
  logic signed [kce_pkg::DIFF_W-1:0] mdiff_q;
  logic signed [kce_pkg::SQ_W-1:0]   mprod;
  logic [kce_pkg::SQ_W-1:0]          msq_q;
  kce_pkg::dist_t           move_acc;
  kce_pkg::dist_t           msum;
  logic                     settled;
  logic [kce_pkg::LIM_W-1:0] pass_cnt;
  kce_pkg::out_item_t       out_q;
  kce_pkg::coord_t          pbuf [ND];

  kce_pkg::coord_t cent_all [NC][ND];
  kce_pkg::sum_t   sum_all  [NC][ND];
  kce_pkg::cnt_t   cnt_all  [NC];
  kce_pkg::tok_t   tok      [NC+1];
  kce_pkg::tok_t   tok_last;
  kce_pkg::ctl_t   ctl;

  logic [kce_pkg::DR_W-1:0] dim_cfg;
  logic [kce_pkg::K_W-1:0]  k_cfg;
  logic                     accept;
  logic                     cip_wr;
  logic                     pl_room;
  logic [3:0]               cip_inc;
  kce_pkg::cnt_t            pl_new;
  logic                     ram_we;
  logic [kce_pkg::RAM_AW-1:0] waddr;
  logic [kce_pkg::RAM_AW-1:0] raddr;
  kce_pkg::coord_t          rdata;
  logic                     issue_dist;
  logic                     dist_last;
  logic                     slot_free;
  logic                     out_load;
  logic                     j_last;
  logic                     d_last;
  kce_pkg::coord_t          sel_old;
  kce_pkg::sum_t            sel_sum;
  kce_pkg::cnt_t            sel_cnt;
  logic                     div_start;
  logic                     div_done;
  kce_pkg::coord_t          quot;
  logic                     moved;

  assign dim_cfg  = kce_pkg::eff_dim(dimension);
  assign k_cfg    = kce_pkg::eff_k(cluster_count);
  assign in_ready = state == ST_LOAD;
  assign accept   = in_valid && in_ready;
  assign cip_wr   = cip < dim_cfg;
  assign pl_room  = pl < kce_pkg::MAX_POINT_COUNT;
  assign cip_inc  = cip_wr ? cip + 4'd1 : cip;
  assign pl_new   = ((in_data.end_of_point || in_data.end_of_set) && cip_inc >= dim_cfg
                     && pl_room) ? pl + 1'b1 : pl;
  assign ram_we   = accept && cip_wr && pl_room;
  assign waddr    = {pl[kce_pkg::PT_AW-1:0], cip[DD-1:0]};
  assign raddr    = (state == ST_INIT)
                  ? {kce_pkg::PT_AW'(ini_cnt[IW-1:DD]), ini_cnt[DD-1:0]}
                  : {pt[kce_pkg::PT_AW-1:0], step[DD-1:0]};

  assign issue_dist = state == ST_DIST && step < run_dim;
  assign dist_last  = step == run_dim + 4'd2;
  assign slot_free  = !out_valid || out_ready;
  assign out_load   = (state == ST_ERR || state == ST_OUT) && slot_free;
  assign j_last     = {1'b0, j} == run_k - 4'd1;
  assign d_last     = {1'b0, d} == run_dim - 4'd1;
  assign sel_old    = cent_all[j][d];
  assign sel_sum    = sum_all[j][d];
  assign sel_cnt    = cnt_all[j];
  assign div_start  = state == ST_DSTART && sel_cnt != '0;
  assign mprod      = mdiff_q * mdiff_q;
  assign msum       = move_acc + kce_pkg::dist_t'(msq_q);
  assign moved      = msum >= kce_pkg::dist_t'(converge_threshold_sq);
  assign out_data   = out_q;

  always_comb begin
    ctl            = '0;
    ctl.feed_valid = rd_v;
    ctl.feed_d     = rd_d;
    ctl.clear_pass = state == ST_PSTART;
    ctl.clear_dist = state == ST_DIST && step == 4'd0;
    ctl.acc_en     = state == ST_ARGMIN && tok_last.valid;
    ctl.acc_idx    = tok_last.idx;
    ctl.k          = run_k;
    if (state == ST_INIT) begin
      ctl.cent_we  = ini_v;
      ctl.cent_idx = ini_a[IW-1:DD];
      ctl.cent_d   = ini_a[DD-1:0];
      ctl.cent_val = rdata;
    end else begin
      ctl.cent_we  = state == ST_MDIFF;
      ctl.cent_idx = j;
      ctl.cent_d   = d;
      ctl.cent_val = nv_q;
    end
  end

  kce_ram #(
    .WIDTH(kce_pkg::COORD_WIDTH),
    .DEPTH(kce_pkg::RAM_DEPTH)
  ) u_points (
    .clk  (clk),
    .we   (ram_we),
    .waddr(waddr),
    .wdata(in_data.coord_value),
    .raddr(raddr),
    .rdata(rdata)
  );

  kce_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(sel_sum),
    .divisor (sel_cnt),
    .done    (div_done),
    .quotient(quot)
  );

  assign tok[0] = '{valid: tok_start, best: '0, idx: '0};
  assign tok_last = tok[NC];

  for (genvar g = 0; g < NC; g++) begin : g_cell
    kce_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cell_id   (CL'(g)),
      .ctl       (ctl),
      .feed_coord(rdata),
      .pbuf      (pbuf),
      .tok_in    (tok[g]),
      .tok_out   (tok[g+1]),
      .cent      (cent_all[g]),
      .sums      (sum_all[g]),
      .count     (cnt_all[g])
    );
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cluster_count         <= 4'd2;
      iteration_limit       <= 10'd400;
      dimension             <= 4'd2;
      converge_threshold_sq <= 40'd17;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kce_pkg::REG_CLUSTER_COUNT:   cluster_count   <= cfg_data[kce_pkg::K_W-1:0];
        kce_pkg::REG_ITERATION_LIMIT: iteration_limit <= cfg_data[kce_pkg::LIM_W-1:0];
        kce_pkg::REG_DIMENSION:       dimension       <= cfg_data[kce_pkg::DR_W-1:0];
        kce_pkg::REG_THRESHOLD:       converge_threshold_sq <= cfg_data[kce_pkg::THR_W-1:0];
      endcase
    end
  end

  // point buffer of the point under test
  always_ff @(posedge clk) begin
    if (rd_v) pbuf[rd_d] <= rdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      pl        <= '0;
      cip       <= '0;
      ini_v     <= 1'b0;
      rd_v      <= 1'b0;
      tok_start <= 1'b0;
      out_valid <= 1'b0;
      pass_cnt  <= '0;
    end else begin
      rd_v      <= issue_dist;
      rd_d      <= step[DD-1:0];
      tok_start <= state == ST_DIST && dist_last;
      if (out_ready && !out_load) out_valid <= 1'b0;
      unique case (state)
        ST_LOAD: begin
          if (accept) begin
            if (in_data.end_of_set) begin
              run_k   <= k_cfg;
              run_dim <= dim_cfg;
              cip     <= 4'd0;
              if (pl_new <= kce_pkg::cnt_t'(k_cfg)) begin
                pl    <= '0;
                state <= ST_ERR;
              end else begin
                pl      <= pl_new;
                ini_cnt <= '0;
                state   <= ST_INIT;
              end
            end else begin
              pl  <= pl_new;
              cip <= in_data.end_of_point ? 4'd0 : cip_inc;
            end
          end
        end
        ST_ERR: begin
          if (slot_free) begin
            out_q     <= '{centroid_coord: '0, centroid_index: '0, coord_index: '0,
                           status: kce_pkg::STATUS_FEW, passes_run: '0,
                           last_result: 1'b1};
            out_valid <= 1'b1;
            state     <= ST_LOAD;
          end
        end
        ST_INIT: begin
          // seed centroids from the first k points, one coordinate a cycle
          ini_v   <= !ini_cnt[IW];
          ini_a   <= ini_cnt[IW-1:0];
          ini_cnt <= ini_cnt + 1'b1;
          if (ini_cnt[IW]) begin
            pass_cnt <= '0;
            state    <= ST_PSTART;
          end
        end
        ST_PSTART: begin
          pt       <= '0;
          step     <= '0;
          j        <= '0;
          d        <= '0;
          move_acc <= '0;
          settled  <= 1'b1;
          state    <= (pass_cnt < iteration_limit) ? ST_DIST : ST_OUT;
        end
        ST_DIST: begin
          if (dist_last) begin
            step  <= '0;
            state <= ST_ARGMIN;
          end else begin
            step <= step + 4'd1;
          end
        end
        ST_ARGMIN: begin
          if (tok_last.valid) begin
            pt    <= pt + 1'b1;
            state <= (pt + 1'b1 == pl) ? ST_DSTART : ST_DIST;
          end
        end
        ST_DSTART: begin
          if (sel_cnt == '0) begin
            nv_q  <= sel_old;
            state <= ST_MDIFF;
          end else begin
            state <= ST_DWAIT;
          end
        end
        ST_DWAIT: begin
          if (div_done) begin
            nv_q  <= quot;
            state <= ST_MDIFF;
          end
        end
        ST_MDIFF: begin
          mdiff_q <= {nv_q[kce_pkg::COORD_WIDTH-1], nv_q}
                   - {sel_old[kce_pkg::COORD_WIDTH-1], sel_old};
          state   <= ST_MSQ;
        end
        ST_MSQ: begin
          msq_q <= mprod;
          state <= ST_MACC;
        end
        ST_MACC: begin
          if (d_last) begin
            move_acc <= '0;
            if (moved) settled <= 1'b0;
            d <= '0;
            if (j_last) begin
              pass_cnt <= pass_cnt + 1'b1;
              j        <= '0;
              state    <= (settled && !moved) ? ST_OUT : ST_PSTART;
            end else begin
              j     <= j + 1'b1;
              state <= ST_DSTART;
            end
          end else begin
            move_acc <= msum;
            d        <= d + 1'b1;
            state    <= ST_DSTART;
          end
        end
        ST_OUT: begin
          if (slot_free) begin
            out_q.centroid_coord <= sel_old;
            out_q.centroid_index <= 3'(j);
            out_q.coord_index    <= 3'(d);
            out_q.status         <= kce_pkg::STATUS_OK;
            out_q.passes_run     <= pass_cnt;
            out_q.last_result    <= j_last && d_last;
            out_valid            <= 1'b1;
            if (d_last) begin
              d <= '0;
              j <= j + 1'b1;
              if (j_last) begin
                pl    <= '0;
                cip   <= '0;
                state <= ST_LOAD;
              end
            end else begin
              d <= d + 1'b1;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

`include "kmeans_clustering_engine_assert.svh"

  `KCE_ASSERT_IMPLY(a_win_in_range, tok_last.valid, ({1'b0, tok_last.idx} < run_k), "argmin winner beyond active clusters")
  `KCE_ASSERT_IMPLY(a_ram_we_load, ram_we, (state == ST_LOAD), "point memory written outside loading")
  `KCE_ASSERT_IMPLY(a_div_done_wait, div_done, (state == ST_DWAIT), "divider finished with no one waiting")
  `KCE_ASSERT_NEXT(a_err_result, (state == ST_ERR && slot_free), (out_valid && out_q.status && out_q.last_result), "error result not presented")

endmodule

[tb/sv/kmeans_clustering_engine_test.sv]
// Self-checking testbench for the k-means clustering engine.
// Depends on kce_pkg and the kmeans_clustering_engine top level.
`timescale 1ns / 100ps

class centroid_scoreboard;
  // predictor state
  logic [3:0]  k_reg;
  logic [9:0]  limit_reg;
  logic [3:0]  dim_reg;
  logic [39:0] thr_reg;
  longint      pts[kce_pkg::MAX_POINT_COUNT][kce_pkg::MAX_DIMENSION];
  longint      cent[kce_pkg::MAX_CLUSTERS][kce_pkg::MAX_DIMENSION];
  int          n_loaded;
  int          n_coords;
  kce_pkg::out_item_t pending[$];
  int          errors;
  int          checked;
  int          runs;
  int          few_runs;

  function new();
    k_reg = 4'd2; limit_reg = 10'd400; dim_reg = 4'd2; thr_reg = 40'd17;
    n_loaded = 0; n_coords = 0; errors = 0; checked = 0; runs = 0; few_runs = 0;
    foreach (pts[i, j]) pts[i][j] = 0;
  endfunction

  function void write_reg(kce_pkg::cfg_idx_t idx, logic [39:0] val);
    case (idx)
      kce_pkg::REG_CLUSTER_COUNT:   k_reg = val[3:0];
      kce_pkg::REG_ITERATION_LIMIT: limit_reg = val[9:0];
      kce_pkg::REG_DIMENSION:       dim_reg = val[3:0];
      kce_pkg::REG_THRESHOLD:       thr_reg = val;
    endcase
  endfunction

  function longint unsigned sq_diff(longint a, longint b);
    longint unsigned m;
    m = (a > b) ? a - b : b - a;
    if (m >= 64'h1_0000_0000) return '1;
    return m * m;
  endfunction

  function longint unsigned sadd(longint unsigned a, longint unsigned b);
    return (a > ~b) ? '1 : a + b;
  endfunction

  function void cluster(int kk, int dd);
    longint         sums[kce_pkg::MAX_CLUSTERS][kce_pkg::MAX_DIMENSION];
    int             members[kce_pkg::MAX_CLUSTERS];
    longint unsigned best, dist_v, move;
    int             bj, passes;
    bit             settled;
    longint         nv;
    for (int i = 0; i < kk; i++)
      for (int d = 0; d < dd; d++) cent[i][d] = pts[i][d];
    passes = 0;
    while (passes < limit_reg) begin
      settled = 1;
      foreach (sums[i, j]) sums[i][j] = 0;
      foreach (members[i]) members[i] = 0;
      for (int p = 0; p < n_loaded; p++) begin
        best = 0; bj = 0;
        for (int j = 0; j < kk; j++) begin
          dist_v = 0;
          for (int d = 0; d < dd; d++) dist_v = sadd(dist_v, sq_diff(pts[p][d], cent[j][d]));
          if (j == 0 || dist_v < best) begin
            best = dist_v; bj = j;
          end
        end
        for (int d = 0; d < dd; d++) sums[bj][d] += pts[p][d];
        members[bj]++;
      end
      for (int j = 0; j < kk; j++) begin
        move = 0;
        for (int d = 0; d < dd; d++) begin
          nv = cent[j][d];
          if (members[j] > 0) nv = sums[j][d] / members[j];  // truncates toward zero
          move = sadd(move, sq_diff(nv, cent[j][d]));
          cent[j][d] = nv;
        end
        if (move >= {24'd0, thr_reg}) settled = 0;
      end
      passes++;
      if (settled) break;
    end
    for (int i = 0; i < kk; i++)
      for (int d = 0; d < dd; d++) begin
        kce_pkg::out_item_t r;
        r.centroid_coord = cent[i][d][23:0];
        r.centroid_index = i[2:0];
        r.coord_index = d[2:0];
        r.status = kce_pkg::STATUS_OK;
        r.passes_run = passes[9:0];
        r.last_result = (i == kk - 1 && d == dd - 1);
        pending.push_back(r);
      end
  endfunction

  function void note_input(kce_pkg::in_item_t it);
    int kk, dd;
    kce_pkg::out_item_t r;
    kk = (k_reg < 2) ? 2 : (k_reg > kce_pkg::MAX_CLUSTERS) ? kce_pkg::MAX_CLUSTERS : k_reg;
    dd = (dim_reg < 1) ? 1 : (dim_reg > kce_pkg::MAX_DIMENSION) ? kce_pkg::MAX_DIMENSION
                                                                 : dim_reg;
    if (n_coords < dd && n_loaded < kce_pkg::MAX_POINT_COUNT)
      pts[n_loaded][n_coords] = it.coord_value;
    if (n_coords < dd) n_coords++;
    if (it.end_of_point || it.end_of_set) begin
      if (n_coords >= dd && n_loaded < kce_pkg::MAX_POINT_COUNT) n_loaded++;
      n_coords = 0;
    end
    if (!it.end_of_set) return;
    runs++;
    if (n_loaded <= kk) begin
      r = '0;
      r.status = kce_pkg::STATUS_FEW;
      r.last_result = 1'b1;
      pending.push_back(r);
      few_runs++;
    end else cluster(kk, dd);
    n_loaded = 0;
    n_coords = 0;
  endfunction

  function void check_result(kce_pkg::out_item_t got);
    kce_pkg::out_item_t exp_r;
    checked++;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %p", $time, got);
      errors++;
      return;
    end
    exp_r = pending.pop_front();
    if (got !== exp_r) begin
      $display("%0t: mismatch expected %p actual %p", $time, exp_r, got);
      errors++;
    end
  endfunction
endclass

module kmeans_clustering_engine_test;
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  kce_pkg::in_item_t  in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  kce_pkg::out_item_t out_data;
  logic        cfg_we = 1'b0;
  kce_pkg::cfg_idx_t  cfg_index = kce_pkg::REG_CLUSTER_COUNT;
  logic [39:0] cfg_data = '0;

  centroid_scoreboard sb = new();
  int  send_idle_pct = 17;
  int  recv_idle_pct = 49;
  int  hold_off = 0;
  bit  hold_start = 1'b0;
  bit  hold_used = 1'b0;
  int  cycles = 0;
  int  sent = 0;
  int  cur_dim = 2;
  int  k_rand;
  localparam int CYCLE_LIMIT = 15_000_000;
  localparam int HOLD_CYCLES = 40_000;

  kmeans_clustering_engine dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else if (hold_start && !hold_used) begin
      hold_off <= HOLD_CYCLES;
      hold_used <= 1'b1;
      out_ready <= 1'b0;
    end else
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic set_reg(kce_pkg::cfg_idx_t idx, logic [39:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  // valid stays up after a transfer; the next send or drain replaces it
  task automatic send(logic signed [23:0] v, bit eop, bit eos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{coord_value: v, end_of_point: eop, end_of_set: eos};
    do @(posedge clk); while (!in_ready);
    sb.note_input(in_data);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // clusters around a few random centers, small spread
  task automatic send_set(int npts, int spread, bit long_pts);
    logic signed [23:0] ctr[4][8];
    int c, extra;
    foreach (ctr[i, j]) ctr[i][j] = $urandom_range(24'hFFFFFF);
    for (int p = 0; p < npts; p++) begin
      c = $urandom_range(3);
      extra = (long_pts && $urandom_range(9) == 0) ? 1 : 0;
      if (!long_pts && cur_dim > 1 && $urandom_range(19) == 0) extra = -1;  // short point
      for (int d = 0; d < cur_dim + extra; d++)
        send(ctr[c][d % 8] + $signed(24'($urandom_range(2 * spread) - spread)),
             d == cur_dim + extra - 1, p == npts - 1 && d == cur_dim + extra - 1);
    end
  endtask

  task automatic config_all(int k, int lim, int dim, logic [39:0] thr);
    set_reg(kce_pkg::REG_CLUSTER_COUNT, k);
    set_reg(kce_pkg::REG_ITERATION_LIMIT, lim);
    set_reg(kce_pkg::REG_DIMENSION, dim);
    set_reg(kce_pkg::REG_THRESHOLD, thr);
    cfg_we <= 1'b0;
    cur_dim = (dim < 1) ? 1 : (dim > 8) ? 8 : dim;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, too few points, short/long points, end_of_set mid-point
    send(24'sh7FFFFF, 0, 0); send(-24'sd8388608, 1, 0);
    send(-24'sd8388608, 1, 0);                      // short point
    send(24'sd0, 0, 0); send(24'sd1, 0, 0); send(24'sd5, 1, 0);  // long point
    send(24'sh7FFFFF, 0, 1);                        // set end mid-point -> too few
    drain();
    send(24'sh7FFFFF, 0, 0); send(24'sh7FFFFF, 1, 0);
    send(-24'sd8388608, 0, 0); send(-24'sd8388608, 1, 0);
    send(24'sd0, 0, 0); send(24'sd0, 1, 0);
    send(24'sd100, 0, 0); send(-24'sd100, 1, 1);   // extreme distances
    drain();
    config_all(0, 0, 0, 40'd0);                    // k acts as 2, no passes, dim 1
    for (int i = 0; i < 5; i++) send(24'(i * 1000), 1, i == 4);
    drain();
    config_all(15, 999, 15, 40'hFF_FFFF_FFFF);     // k 8, dim 8, huge threshold
    send_set(10, 50, 1);
    drain();

    // random phases, sender and receiver idling swapped, then none
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin send_idle_pct = 49; recv_idle_pct = 17; end
      if (ph == 2) begin send_idle_pct = 0; recv_idle_pct = 0; end
      for (int s = 0; s < 4; s++) begin
        k_rand = $urandom_range(2, 8);
        config_all(k_rand, $urandom_range(2, 20), $urandom_range(1, 4),
                   ($urandom_range(3) == 0) ? 40'd0 : 40'($urandom_range(5000)));
        if (ph == 0 && s == 0) begin
          // long receiver stall; the next set is offered while the block is full
          hold_start <= 1'b1;
          send_set(k_rand + $urandom_range(1, 5), 300, 0);
        end
        send_set(k_rand + $urandom_range(1, 5),
                 $urandom_range(2) == 0 ? 8000 : 300, $urandom_range(1));
        drain();
      end
    end

    while (sb.pending.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("%0d items sent, %0d data sets (%0d too small), %0d results checked",
             sent, sb.runs, sb.few_runs, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule
